[hdl/bcw_pkg.sv]
// Shared types, ALU opcode codes and ALU function for the bus control word datapath.
// No dependencies; imported by bcw_exec and bus_control_word_datapath.
package bcw_pkg;

   // ALU opcode codes held in the alu_op register
   localparam logic [7:0] ALU_ADD = 8'd1;
   localparam logic [7:0] ALU_SUB = 8'd2;
   localparam logic [7:0] ALU_NOT = 8'd3;
   localparam logic [7:0] ALU_AND = 8'd4;
   localparam logic [7:0] ALU_OR  = 8'd5;

   // Read mask bit positions (bus sources)
   localparam int RD_A   = 0;
   localparam int RD_B   = 1;
   localparam int RD_C   = 2;
   localparam int RD_D   = 3;
   localparam int RD_ALU = 4;

   // Write mask bit positions (bus destinations)
   localparam int WR_A      = 0;
   localparam int WR_B      = 1;
   localparam int WR_C      = 2;
   localparam int WR_D      = 3;
   localparam int WR_ALU_A  = 4;
   localparam int WR_ALU_B  = 5;
   localparam int WR_ALU_OP = 6;
   localparam int WR_MADR   = 7;
   localparam int WR_IPTR   = 8;
   localparam int WR_SPTR   = 9;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   // One control word
   typedef struct packed {
      logic       write_port;
      logic [9:0] write_mask;
      logic [4:0] read_mask;
      logic [7:0] bus_literal;
      logic       use_condition;
   } word_type;

   // One result
   typedef struct packed {
      logic [7:0] mem_address;
      logic [7:0] stack_pointer;
      logic [7:0] instr_pointer;
      logic [7:0] io_data;
      logic [7:0] io_port;
      logic       io_valid;
      logic       executed;
   } result_type;

   // ALU output; undefined opcodes give zero
   function automatic logic [7:0] alu_result(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] op);
      logic [7:0] r;
      case (op)
         ALU_ADD: r = a + b;
         ALU_SUB: r = a - b;
         ALU_NOT: r = (a == 8'd0) ? 8'd1 : 8'd0;
         ALU_AND: r = a & b;
         ALU_OR:  r = a | b;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

endpackage

[hdl/bus_control_word_datapath.sv]
// Top level of the bus control word datapath: request register, executor, response register.
// Depends on bcw_pkg and bcw_exec.
//
//   Channel  | Direction | Ports                       | Contents
//   req      | in        | req_tvalid/tready/tdata[31:0] | one control word per transaction
//   rsp      | out       | rsp_tvalid/tready/tdata[47:0] | one result per control word
//
// Each word waits in the request register and is executed as it moves
// to the response register; one word per clock is sustained while rsp_tready is high.
// The response register stalls on rsp_tready low and the request register stalls
// behind it. Synchronous reset clears all machine registers and both valid flags.
module bus_control_word_datapath
   import bcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] use_condition, [8:1] bus_literal, [13:9] read_mask, [23:14] write_mask,
   // [24] write_port, [31:25] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] executed, [1] io_valid, [9:2] io_port, [17:10] io_data, [25:18] instr_pointer,
   // [33:26] stack_pointer, [41:34] mem_address, [47:42] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       req_valid_ff;
   word_type   req_word_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   logic       rsp_load;
   logic       exec_step;
   result_type exec_result;

   // Handshake: response slot frees when empty or taken; request moves when slot frees
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign exec_step  = req_valid_ff && rsp_load;
   assign req_tready = !req_valid_ff || rsp_load;

   bcw_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .step   (exec_step),
      .word   (req_word_ff),
      .result (exec_result)
   );

   // Hold the request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_word_ff <= req_tdata[$bits(word_type)-1:0];
      end
   end

   // Hold the response transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_step) begin
         rsp_data_ff <= exec_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, rsp_data_ff};

endmodule

[hdl/bcw_exec.sv]
// Register file, ALU and bus of the control word machine; executes one word per step.
// Depends on bcw_pkg for word_type, result_type and alu_result.
module bcw_exec
   import bcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,      // commit the word this cycle
   input  word_type   word,
   output result_type result     // outcome of the word against current state
);

   logic [7:0] reg_a_ff, reg_b_ff, reg_c_ff, reg_d_ff;
   logic [7:0] alu_a_ff, alu_b_ff, alu_op_ff;
   logic [7:0] madr_ff, iptr_ff, sptr_ff;
   logic [7:0] reg_a_in, reg_b_in, reg_c_in, reg_d_in;
   logic [7:0] alu_a_in, alu_b_in, alu_op_in;
   logic [7:0] madr_in, iptr_in, sptr_in;

   logic       exec;
   logic [7:0] alu_out;
   logic [7:0] bus;
   logic [9:0] wr;

   // Drive the bus and decide which registers load it
   always_comb begin
      exec    = !word.use_condition || (reg_a_ff != 8'd0);
      alu_out = alu_result(alu_a_ff, alu_b_ff, alu_op_ff);
      bus     = word.bus_literal
              | (word.read_mask[RD_A]   ? reg_a_ff : 8'd0)
              | (word.read_mask[RD_B]   ? reg_b_ff : 8'd0)
              | (word.read_mask[RD_C]   ? reg_c_ff : 8'd0)
              | (word.read_mask[RD_D]   ? reg_d_ff : 8'd0)
              | (word.read_mask[RD_ALU] ? alu_out  : 8'd0);
      wr      = exec ? word.write_mask : 10'd0;

      reg_a_in  = wr[WR_A]      ? bus : reg_a_ff;
      reg_b_in  = wr[WR_B]      ? bus : reg_b_ff;
      reg_c_in  = wr[WR_C]      ? bus : reg_c_ff;
      reg_d_in  = wr[WR_D]      ? bus : reg_d_ff;
      alu_a_in  = wr[WR_ALU_A]  ? bus : alu_a_ff;
      alu_b_in  = wr[WR_ALU_B]  ? bus : alu_b_ff;
      alu_op_in = wr[WR_ALU_OP] ? bus : alu_op_ff;
      madr_in   = wr[WR_MADR]   ? bus : madr_ff;
      iptr_in   = wr[WR_IPTR]   ? bus : iptr_ff;
      sptr_in   = wr[WR_SPTR]   ? bus : sptr_ff;
   end

   // Build the result from the post-write state
   always_comb begin
      result.executed      = exec;
      result.io_valid      = exec && word.write_port;
      result.io_port       = result.io_valid ? madr_in : 8'd0;
      result.io_data       = result.io_valid ? bus : 8'd0;
      result.instr_pointer = iptr_in;
      result.stack_pointer = sptr_in;
      result.mem_address   = madr_in;
   end

   // Commit register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_a_ff  <= 8'd0;
         reg_b_ff  <= 8'd0;
         reg_c_ff  <= 8'd0;
         reg_d_ff  <= 8'd0;
         alu_a_ff  <= 8'd0;
         alu_b_ff  <= 8'd0;
         alu_op_ff <= 8'd0;
         madr_ff   <= 8'd0;
         iptr_ff   <= 8'd0;
         sptr_ff   <= 8'd0;
      end else if (step) begin
         reg_a_ff  <= reg_a_in;
         reg_b_ff  <= reg_b_in;
         reg_c_ff  <= reg_c_in;
         reg_d_ff  <= reg_d_in;
         alu_a_ff  <= alu_a_in;
         alu_b_ff  <= alu_b_in;
         alu_op_ff <= alu_op_in;
         madr_ff   <= madr_in;
         iptr_ff   <= iptr_in;
         sptr_ff   <= sptr_in;
      end
   end

endmodule
